// ----- rtl/mrst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_pkg
// Shared types and constants of the message rate statistics table.
// ----------------------------------------------------------------------------
package mrst_pkg;

  localparam int SLOTS    = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W     = 24;
  localparam int BYTE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 18;
  localparam int SLOT_W   = 4;
  // Dividend width of the divider: the rate numerator needs 18 bits.
  localparam int DIV_NW   = 18;
  localparam int DIV_CW   = $clog2(DIV_NW);
  localparam int RATE_NUM = 256000;
  localparam int BLEND_DEN = 10;
  // Width of 9*avg + rate ahead of the divide by ten.
  localparam int ACC_W    = 22;
  // The divide by ten is a multiply by ceil(2^24/10) and a shift by 24,
  // which is exact for every dividend below 2^22.
  localparam int RECIP_10 = 1677722;
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 21;
  localparam int PROD_W   = ACC_W + RECIP_W;

  typedef struct packed {
    logic [ID_W-1:0]   msg_id;
    logic [BYTE_W-1:0] sys_id;
    logic [BYTE_W-1:0] comp_id;
    logic [TIME_W-1:0] last_time;
    logic [RATE_W-1:0] avg_rate;
    logic              avg_valid;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{msg_id: '0, sys_id: '0, comp_id: '0,
                                     last_time: '0, avg_rate: '0, avg_valid: 1'b1};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DIV_RATE,
    ST_DIV_BLEND,
    ST_WRITE
  } state_t;

endpackage

// ----- rtl/mrst_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_table
// Slot memory with one registered read port, one write port and per-entry
// valid flags; an entry never written reads as the reset entry.
// ----------------------------------------------------------------------------
module mrst_table
  import mrst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  tbl_wr_t          wr
);

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  entry_t           rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : ENTRY_RESET;

endmodule

// ----- rtl/mrst_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrst_div
  import mrst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [TIME_W-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [TIME_W-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              active_r;
  logic              done_r;

  logic [TIME_W:0]   rem_sh;
  logic              ge;
  logic [TIME_W:0]   diff;

  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (active_r) begin
      // The partial remainder stays below the divisor, so it fits in TIME_W bits.
      rem_r <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ----- rtl/message_rate_stats_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_rate_stats_table_unit
// Per-stream receive rate table: slot search, replacement of the oldest slot
// and a running average of 256000/(now-last) in Q10.8 Hz.
// ----------------------------------------------------------------------------
// Steps from accept to the result: scan, drain, decide, then the divide when a rate is
//   possible, the blend when the average was valid, and the write; out_valid is registered.
// Scan reads one entry per cycle; the divider makes one quotient bit per cycle.
// Throughput: one event at a time; busy is high from accept until the one-cycle strobe
//   on out_valid, and the receiver cannot stall.
// Synchronous reset empties the table at once through per-slot valid flags.
// ----------------------------------------------------------------------------
module message_rate_stats_table_unit
  import mrst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   in_msg_id,
  input  logic [BYTE_W-1:0] in_sys_id,
  input  logic [BYTE_W-1:0] in_comp_id,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_new_entry,
  output logic              out_avg_valid,
  output logic [RATE_W-1:0] out_avg_rate
);

  state_t state_r, state_nxt;

  logic [ID_W-1:0]   msg_r;
  logic [BYTE_W-1:0] sys_r;
  logic [BYTE_W-1:0] comp_r;
  logic [TIME_W-1:0] now_r;

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              chk_vld_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  entry_t            hit_ent_r;
  logic [TIME_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [ACC_W-1:0]  acc_r;

  logic [IDX_W-1:0]  sel_r, sel_nxt;
  logic              fresh_r, fresh_nxt;
  logic              avgv_r, avgv_nxt;
  logic [RATE_W-1:0] avg_r, avg_nxt;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_new_r;
  logic              out_avgv_r;
  logic [RATE_W-1:0] out_avg_r;

  entry_t   rd_data;
  tbl_wr_t  wr;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              accept;
  logic              match;
  logic              rate_ok;
  logic [TIME_W-1:0] delta;
  logic [ACC_W-1:0]  blend_acc;
  logic [PROD_W-1:0] blend_prod;
  logic [7:0]        sel_wide;

  assign accept  = start && (state_r == ST_IDLE);
  assign match   = (rd_data.msg_id == msg_r) && (rd_data.sys_id == sys_r) &&
                   (rd_data.comp_id == comp_r);
  assign rate_ok = (hit_ent_r.last_time != '0) && (now_r > hit_ent_r.last_time);
  assign delta   = now_r - hit_ent_r.last_time;
  assign blend_acc = (ACC_W'(hit_ent_r.avg_rate) << 3) + ACC_W'(hit_ent_r.avg_rate)
                   + ACC_W'(div_rsp.quot[RATE_W-1:0]);
  assign blend_prod = PROD_W'(acc_r) * PROD_W'(RECIP_10);

  mrst_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r),
    .rd_data (rd_data),
    .wr      (wr)
  );

  mrst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == IDX_W'(SLOTS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (found_r && rate_ok) state_nxt = ST_DIV_RATE;
        else                    state_nxt = ST_WRITE;
      end
      ST_DIV_RATE: begin
        if (div_rsp.done) begin
          state_nxt = hit_ent_r.avg_valid ? ST_DIV_BLEND : ST_WRITE;
        end
      end
      ST_DIV_BLEND: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: divider request, table write, result values.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'(RATE_NUM);
    div_req.den   = delta;
    wr.en         = 1'b0;
    wr.addr       = sel_r;
    wr.data       = '{msg_id: msg_r, sys_id: sys_r, comp_id: comp_r,
                      last_time: now_r, avg_rate: avg_r, avg_valid: avgv_r};
    sel_nxt       = sel_r;
    fresh_nxt     = fresh_r;
    avgv_nxt      = avgv_r;
    avg_nxt       = avg_r;
    unique case (state_r)
      ST_DECIDE: begin
        if (!found_r) begin
          sel_nxt   = best_idx_r;
          fresh_nxt = 1'b1;
          avgv_nxt  = 1'b0;
          avg_nxt   = '0;
        end else begin
          sel_nxt   = hit_idx_r;
          fresh_nxt = 1'b0;
          avgv_nxt  = 1'b1;
          avg_nxt   = '0;
          div_req.start = rate_ok;
        end
      end
      ST_DIV_RATE: begin
        if (div_rsp.done && !hit_ent_r.avg_valid) begin
          avg_nxt = div_rsp.quot[RATE_W-1:0];
        end
      end
      ST_DIV_BLEND: begin
        avg_nxt = blend_prod[RECIP_SH +: RATE_W];
      end
      ST_WRITE: begin
        wr.en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_WRITE);
      if (accept) begin
        idx_r <= '0;
      end else if (state_r == ST_SCAN && idx_r != IDX_W'(SLOTS - 1)) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign sel_wide = 8'(sel_r);

  // Datapath: search bookkeeping on the registered read beat, result values.
  always_ff @(posedge clk) begin
    chk_idx_r <= idx_r;
    sel_r     <= sel_nxt;
    fresh_r   <= fresh_nxt;
    avgv_r    <= avgv_nxt;
    avg_r     <= avg_nxt;
    if (accept) begin
      msg_r      <= in_msg_id;
      sys_r      <= in_sys_id;
      comp_r     <= in_comp_id;
      now_r      <= in_now_ms;
      found_r    <= 1'b0;
      best_r     <= '1;
      best_idx_r <= '0;
    end else if (chk_vld_r) begin
      if (match && !found_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_ent_r <= rd_data;
      end
      // Ties go to the later slot, so the compare is less-or-equal.
      if (rd_data.last_time <= best_r) begin
        best_r     <= rd_data.last_time;
        best_idx_r <= chk_idx_r;
      end
    end
    if (state_r == ST_DIV_RATE && div_rsp.done) begin
      acc_r <= blend_acc;
    end
    if (state_r == ST_WRITE) begin
      out_slot_r <= sel_wide[SLOT_W-1:0];
      out_new_r  <= fresh_r;
      out_avgv_r <= avgv_r;
      out_avg_r  <= avg_r;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_new_entry = out_new_r;
  assign out_avg_valid = out_avgv_r;
  assign out_avg_rate  = out_avg_r;

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted event did not start the sequencer");

  a_fresh_is_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_entry && out_avg_valid))
    else $error("claimed slot reported a valid average");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_avg_valid) |-> (out_avg_rate == '0))
    else $error("invalid average not held at zero");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_RATE))
    else $error("divider finished outside the rate step");

endmodule
